// File: rtl/dfu_pkg.sv
// Shared types and constants of the demons force update block.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dfu_pkg;

   localparam int FRAC_BITS = 16;

   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = 64 / DIV_BITS;
   localparam int DIV_LAT    = DIV_STAGES + 1;

   localparam int SQRT_BITS   = 2;
   localparam int SQRT_STAGES = 32 / SQRT_BITS;
   localparam int SQRT_LAT    = SQRT_STAGES + 1;

   localparam logic CSR_NORMALIZATION = 1'b0;
   localparam logic CSR_MAX_LENGTH    = 1'b1;

   localparam logic [31:0] NORMALIZATION_RESET = 32'd65536;
   localparam logic [31:0] MAX_LENGTH_RESET    = 32'd131072;

   typedef struct packed {
      logic signed [15:0] fixed_value;
      logic signed [15:0] moving_value;
      logic               fixed_ok;
      logic               moving_ok;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic signed [31:0] grad_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
      logic signed [31:0] disp_z;
      logic [31:0]        squared_error;
      logic               counted;
   } rsp_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] lo;
      logic [63:0] q;
   } div_state_type;

   typedef struct packed {
      logic [35:0] rem;
      logic [63:0] val;
      logic [31:0] root;
   } sqrt_state_type;

endpackage

`default_nettype wire

// File: rtl/dfu_div.sv
// Pipelined restoring divider: floor({num_hi,num_lo} / den), saturated to 64 bits.
// Advances on en. Depends on dfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfu_div (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] num_hi,
   input  wire logic [63:0] num_lo,
   input  wire logic [63:0] den,
   output logic [63:0]      quo
);

   dfu_pkg::div_state_type st_ff  [dfu_pkg::DIV_STAGES+1];
   logic [63:0]            den_ff [dfu_pkg::DIV_STAGES+1];
   logic                   sat_ff [dfu_pkg::DIV_STAGES+1];

   function automatic dfu_pkg::div_state_type div_step(dfu_pkg::div_state_type s,
                                                       logic [63:0] d);
      dfu_pkg::div_state_type r;
      logic [64:0]            w;
      r = s;
      for (int k = 0; k < dfu_pkg::DIV_BITS; k++) begin
         w    = {r.rem, r.lo[63]};
         r.lo = {r.lo[62:0], 1'b0};
         if (w >= {1'b0, d}) begin
            w   = w - {1'b0, d};
            r.q = {r.q[62:0], 1'b1};
         end else begin
            r.q = {r.q[62:0], 1'b0};
         end
         r.rem = w[63:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0].rem <= num_hi;
         st_ff[0].lo  <= num_lo;
         st_ff[0].q   <= 64'd0;
         den_ff[0]    <= den;
         sat_ff[0]    <= (num_hi >= den);
         for (int i = 1; i <= dfu_pkg::DIV_STAGES; i++) begin
            st_ff[i]  <= div_step(st_ff[i-1], den_ff[i-1]);
            den_ff[i] <= den_ff[i-1];
            sat_ff[i] <= sat_ff[i-1];
         end
      end
   end

   assign quo = sat_ff[dfu_pkg::DIV_STAGES] ? {64{1'b1}} : st_ff[dfu_pkg::DIV_STAGES].q;

endmodule

`default_nettype wire

// File: rtl/dfu_sqrt.sv
// Pipelined integer square root: floor(sqrt(val)) of a 64-bit value.
// Advances on en. Depends on dfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfu_sqrt (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] val,
   output logic [31:0]      root
);

   dfu_pkg::sqrt_state_type st_ff [dfu_pkg::SQRT_STAGES+1];

   function automatic dfu_pkg::sqrt_state_type sqrt_step(dfu_pkg::sqrt_state_type s);
      dfu_pkg::sqrt_state_type r;
      logic [35:0]             w;
      logic [35:0]             trial;
      r = s;
      for (int k = 0; k < dfu_pkg::SQRT_BITS; k++) begin
         w     = {r.rem[33:0], r.val[63:62]};
         r.val = {r.val[61:0], 2'b00};
         trial = {2'b00, r.root, 2'b01};
         if (w >= trial) begin
            w      = w - trial;
            r.root = {r.root[30:0], 1'b1};
         end else begin
            r.root = {r.root[30:0], 1'b0};
         end
         r.rem = w;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0].rem  <= 36'd0;
         st_ff[0].val  <= val;
         st_ff[0].root <= 32'd0;
         for (int i = 1; i <= dfu_pkg::SQRT_STAGES; i++) begin
            st_ff[i] <= sqrt_step(st_ff[i-1]);
         end
      end
   end

   assign root = st_ff[dfu_pkg::SQRT_STAGES].root;

endmodule

`default_nettype wire

// File: rtl/demons_force_update_core.sv
// Top level of the demons force update block: one voxel in, one update out.
// Depends on dfu_pkg, dfu_div and dfu_sqrt.
//
// Use: present a voxel beat on req_valid/req_data; it is taken when req_ready
// is high. Each beat gives exactly one rsp beat, in order, after it flows through
// the input and product stages, a divider for the intensity term, three
// dividers for the force, a square-root unit and three dividers for the length
// clamp, then the output register.
// Throughput is one voxel per cycle while the output is not stalled; every stage
// is a register stage and the dividers and the root resolve two bits per stage.
// The whole pipeline advances together: while rsp_valid is high and rsp_ready
// is low, everything holds and req_ready is low, so no beat is lost or repeated.
// csr_we writes normalization (index 0) or max_update_length (index 1); write
// only while the pipeline is empty.
// Reset (synchronous) empties the pipeline and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module demons_force_update_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dfu_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dfu_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [31:0]      csr_wdata
);

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             diff_neg;
      logic [15:0]      adiff;
      logic [2:0]       gneg;
      logic [2:0][31:0] gmag;
   } sa_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic [2:0]       neg;
      logic [31:0]      sq;
      logic [2:0][63:0] gp;
      logic [2:0][47:0] ag;
   } sb_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             norm_zero;
      logic [2:0]       neg;
      logic [31:0]      sq;
      logic [63:0]      gsq;
      logic [2:0][47:0] ag;
   } s1_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic [2:0]       neg;
      logic [31:0]      sq;
      logic [63:0]      den;
      logic [2:0][47:0] ag;
   } sd_type;

   typedef struct packed {
      logic       valid;
      logic       ok;
      logic       den_zero;
      logic [2:0] neg;
      logic [31:0] sq;
   } s2_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             den_zero;
      logic [2:0]       neg;
      logic [31:0]      sq;
      logic [2:0][31:0] umag;
   } sf_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             den_zero;
      logic [2:0]       neg;
      logic [31:0]      sq;
      logic [2:0][31:0] umag;
      logic [2:0][63:0] up;
      logic [2:0][63:0] prod;
      logic [63:0]      max_sq;
   } sg_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             den_zero;
      logic             clamp;
      logic [2:0]       neg;
      logic [31:0]      sq;
      logic [2:0][31:0] umag;
      logic [2:0][63:0] prod;
      logic [63:0]      mag2;
   } sh_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             den_zero;
      logic             clamp;
      logic [2:0]       neg;
      logic [31:0]      sq;
      logic [2:0][31:0] umag;
      logic [2:0][63:0] prod;
   } s3_type;

   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             den_zero;
      logic             clamp;
      logic [2:0]       neg;
      logic [31:0]      sq;
      logic [2:0][31:0] umag;
   } s4_type;

   logic en;

   logic [31:0] norm_ff;
   logic [31:0] max_len_ff;

   sa_type sa_ff, sa_in;
   sb_type sb_ff, sb_in;
   s1_type s1_in;
   s1_type s1_ff [dfu_pkg::DIV_LAT];
   sd_type sd_ff, sd_in;
   s2_type s2_in;
   s2_type s2_ff [dfu_pkg::DIV_LAT];
   sf_type sf_ff, sf_in;
   sg_type sg_ff, sg_in;
   sh_type sh_ff, sh_in;
   s3_type s3_ff [dfu_pkg::SQRT_LAT];
   s4_type s4_in;
   s4_type s4_ff [dfu_pkg::DIV_LAT];

   logic              rsp_valid_ff;
   dfu_pkg::rsp_type  rsp_ff, rsp_in;

   logic [127:0]      term_num;
   logic [63:0]       term_quo;
   logic [2:0][127:0] force_num;
   logic [2:0][63:0]  force_quo;
   logic [63:0]       force_den;
   logic [31:0]       root;
   logic [63:0]       clamp_den;
   logic [2:0][63:0]  clamp_num;
   logic [2:0][63:0]  clamp_quo;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff    <= dfu_pkg::NORMALIZATION_RESET;
         max_len_ff <= dfu_pkg::MAX_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dfu_pkg::CSR_NORMALIZATION: norm_ff    <= csr_wdata;
            dfu_pkg::CSR_MAX_LENGTH:    max_len_ff <= csr_wdata;
            default:                    norm_ff    <= norm_ff;
         endcase
      end
   end

   // stage A: difference and magnitudes
   always_comb begin
      logic signed [16:0] diff;
      logic signed [31:0] g [3];
      diff = 17'(req_data.fixed_value) - 17'(req_data.moving_value);
      g[0] = req_data.grad_x;
      g[1] = req_data.grad_y;
      g[2] = req_data.grad_z;
      sa_in.valid    = req_valid;
      sa_in.ok       = req_data.fixed_ok && req_data.moving_ok;
      sa_in.diff_neg = diff[16];
      sa_in.adiff    = diff[16] ? 16'(-diff) : diff[15:0];
      for (int c = 0; c < 3; c++) begin
         sa_in.gneg[c] = g[c][31];
         sa_in.gmag[c] = g[c][31] ? (~g[c] + 32'd1) : g[c];
      end
   end

   // stage B: products
   always_comb begin
      sb_in.valid = sa_ff.valid;
      sb_in.ok    = sa_ff.ok;
      sb_in.sq    = 32'(sa_ff.adiff) * 32'(sa_ff.adiff);
      for (int c = 0; c < 3; c++) begin
         sb_in.neg[c] = sa_ff.diff_neg ^ sa_ff.gneg[c];
         sb_in.gp[c]  = 64'(sa_ff.gmag[c]) * 64'(sa_ff.gmag[c]);
         sb_in.ag[c]  = 48'(sa_ff.adiff) * 48'(sa_ff.gmag[c]);
      end
   end

   assign term_num = 128'(sb_ff.sq) << (3 * dfu_pkg::FRAC_BITS);

   dfu_div u_term_div (
      .clock  (clock),
      .en     (en),
      .num_hi (term_num[127:64]),
      .num_lo (term_num[63:0]),
      .den    ({32'd0, norm_ff}),
      .quo    (term_quo)
   );

   always_comb begin
      s1_in.valid     = sb_ff.valid;
      s1_in.ok        = sb_ff.ok;
      s1_in.norm_zero = (norm_ff == 32'd0);
      s1_in.neg       = sb_ff.neg;
      s1_in.sq        = sb_ff.sq;
      s1_in.gsq       = sb_ff.gp[0] + sb_ff.gp[1] + sb_ff.gp[2];
      s1_in.ag        = sb_ff.ag;
   end

   // stage D: saturated denominator
   always_comb begin
      logic [63:0] term;
      logic [64:0] sum;
      s1_type      s;
      s            = s1_ff[dfu_pkg::DIV_LAT-1];
      term         = s.norm_zero ? {64{1'b1}} : term_quo;
      sum          = {1'b0, s.gsq} + {1'b0, term};
      sd_in.valid  = s.valid;
      sd_in.ok     = s.ok;
      sd_in.neg    = s.neg;
      sd_in.sq     = s.sq;
      sd_in.den    = sum[64] ? {64{1'b1}} : sum[63:0];
      sd_in.ag     = s.ag;
   end

   assign force_den = (sd_ff.den == 64'd0) ? 64'd1 : sd_ff.den;
   assign clamp_num = s3_ff[dfu_pkg::SQRT_LAT-1].prod;

   for (genvar c = 0; c < 3; c++) begin : g_force
      assign force_num[c] = 128'(sd_ff.ag[c]) << (2 * dfu_pkg::FRAC_BITS);

      dfu_div u_force_div (
         .clock  (clock),
         .en     (en),
         .num_hi (force_num[c][127:64]),
         .num_lo (force_num[c][63:0]),
         .den    (force_den),
         .quo    (force_quo[c])
      );

      dfu_div u_clamp_div (
         .clock  (clock),
         .en     (en),
         .num_hi (64'd0),
         .num_lo (clamp_num[c]),
         .den    (clamp_den),
         .quo    (clamp_quo[c])
      );
   end

   always_comb begin
      s2_in.valid    = sd_ff.valid;
      s2_in.ok       = sd_ff.ok;
      s2_in.den_zero = (sd_ff.den == 64'd0);
      s2_in.neg      = sd_ff.neg;
      s2_in.sq       = sd_ff.sq;
   end

   // stage F: saturate force components
   always_comb begin
      logic [63:0] lim;
      s2_type      s;
      s              = s2_ff[dfu_pkg::DIV_LAT-1];
      sf_in.valid    = s.valid;
      sf_in.ok       = s.ok;
      sf_in.den_zero = s.den_zero;
      sf_in.neg      = s.neg;
      sf_in.sq       = s.sq;
      for (int c = 0; c < 3; c++) begin
         lim           = s.neg[c] ? 64'h8000_0000 : 64'h7FFF_FFFF;
         sf_in.umag[c] = (force_quo[c] > lim) ? lim[31:0] : force_quo[c][31:0];
      end
   end

   // stage G: squares and scaled magnitudes
   always_comb begin
      sg_in.valid    = sf_ff.valid;
      sg_in.ok       = sf_ff.ok;
      sg_in.den_zero = sf_ff.den_zero;
      sg_in.neg      = sf_ff.neg;
      sg_in.sq       = sf_ff.sq;
      sg_in.umag     = sf_ff.umag;
      sg_in.max_sq   = 64'(max_len_ff) * 64'(max_len_ff);
      for (int c = 0; c < 3; c++) begin
         sg_in.up[c]   = 64'(sf_ff.umag[c]) * 64'(sf_ff.umag[c]);
         sg_in.prod[c] = 64'(sf_ff.umag[c]) * 64'(max_len_ff);
      end
   end

   // stage H: squared length and clamp decision
   always_comb begin
      sh_in.valid    = sg_ff.valid;
      sh_in.ok       = sg_ff.ok;
      sh_in.den_zero = sg_ff.den_zero;
      sh_in.neg      = sg_ff.neg;
      sh_in.sq       = sg_ff.sq;
      sh_in.umag     = sg_ff.umag;
      sh_in.prod     = sg_ff.prod;
      sh_in.mag2     = sg_ff.up[0] + sg_ff.up[1] + sg_ff.up[2];
      sh_in.clamp    = (sh_in.mag2 > sg_ff.max_sq);
   end

   dfu_sqrt u_len_sqrt (
      .clock (clock),
      .en    (en),
      .val   (sh_ff.mag2),
      .root  (root)
   );

   assign clamp_den = (root == 32'd0) ? 64'd1 : {32'd0, root};

   always_comb begin
      s3_type s;
      s              = s3_ff[dfu_pkg::SQRT_LAT-1];
      s4_in.valid    = s.valid;
      s4_in.ok       = s.ok;
      s4_in.den_zero = s.den_zero;
      s4_in.clamp    = s.clamp;
      s4_in.neg      = s.neg;
      s4_in.sq       = s.sq;
      s4_in.umag     = s.umag;
   end

   // output stage: pick, sign and mask
   always_comb begin
      logic [31:0] mag [3];
      logic [31:0] u   [3];
      s4_type      s;
      s = s4_ff[dfu_pkg::DIV_LAT-1];
      for (int c = 0; c < 3; c++) begin
         mag[c] = s.clamp ? clamp_quo[c][31:0] : s.umag[c];
         if (!s.ok || s.den_zero) begin
            mag[c] = 32'd0;
         end
         u[c] = s.neg[c] ? (~mag[c] + 32'd1) : mag[c];
      end
      rsp_in.disp_x        = u[0];
      rsp_in.disp_y        = u[1];
      rsp_in.disp_z        = u[2];
      rsp_in.squared_error = s.ok ? s.sq : 32'd0;
      rsp_in.counted       = s.ok;
   end

   // advance the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff.valid  <= 1'b0;
         sb_ff.valid  <= 1'b0;
         sd_ff.valid  <= 1'b0;
         sf_ff.valid  <= 1'b0;
         sg_ff.valid  <= 1'b0;
         sh_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < dfu_pkg::DIV_LAT; i++) begin
            s1_ff[i].valid <= 1'b0;
            s2_ff[i].valid <= 1'b0;
            s4_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i < dfu_pkg::SQRT_LAT; i++) begin
            s3_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         sa_ff    <= sa_in;
         sb_ff    <= sb_in;
         sd_ff    <= sd_in;
         sf_ff    <= sf_in;
         sg_ff    <= sg_in;
         sh_ff    <= sh_in;
         rsp_ff   <= rsp_in;
         s1_ff[0] <= s1_in;
         s2_ff[0] <= s2_in;
         s3_ff[0] <= s3_type'{sh_ff.valid, sh_ff.ok, sh_ff.den_zero, sh_ff.clamp,
                              sh_ff.neg, sh_ff.sq, sh_ff.umag, sh_ff.prod};
         s4_ff[0] <= s4_in;
         for (int i = 1; i < dfu_pkg::DIV_LAT; i++) begin
            s1_ff[i] <= s1_ff[i-1];
            s2_ff[i] <= s2_ff[i-1];
            s4_ff[i] <= s4_ff[i-1];
         end
         for (int i = 1; i < dfu_pkg::SQRT_LAT; i++) begin
            s3_ff[i] <= s3_ff[i-1];
         end
         rsp_valid_ff <= s4_ff[dfu_pkg::DIV_LAT-1].valid;
      end
   end

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_uncounted_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.counted |-> rsp_data.squared_error == 32'd0 &&
      rsp_data.disp_x == 32'sd0 && rsp_data.disp_y == 32'sd0 &&
      rsp_data.disp_z == 32'sd0)
      else $error("uncounted voxel with nonzero result");
`endif

endmodule

`default_nettype wire
